// ===== rtl/utf8d_pkg.sv =====
// Shared types, range limits and result helpers for the UTF-8 stream decoder.
// Used by utf8d_front, utf8d_queue, utf8d_back and utf8_stream_decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

    // One decoded result (code point or error)
    typedef struct packed {
        logic [20:0] code_point;
        logic        is_error;
        logic [2:0]  bytes_used;
    } result_t;

    // Everything one input byte produces: one result, or two when a broken
    // sequence is closed and the byte itself yields a result as well
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } entry_t;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Sequence lengths
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_ONE  = 3'd1;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    // Valid windows of the accumulated value (lead bits kept in the top)
    localparam logic [25:0] LEN2_MIN = 26'h0003080;
    localparam logic [25:0] LEN2_LIM = 26'h0003800;
    localparam logic [25:0] LEN3_MIN = 26'h00e0800;
    localparam logic [25:0] SURR_LO  = 26'h00ed800;
    localparam logic [25:0] SURR_HI  = 26'h00ee000;
    localparam logic [25:0] LEN3_LIM = 26'h00f0000;
    localparam logic [25:0] LEN4_MIN = 26'h3c10000;
    localparam logic [25:0] LEN4_LIM = 26'h3d10000;

    function automatic result_t make_err(input logic [2:0] used);
        result_t r;
        r.code_point = '0;
        r.is_error   = 1'b1;
        r.bytes_used = used;
        return r;
    endfunction

    // Range checks on a complete sequence: overlong, surrogate, too large
    function automatic result_t finish_seq(input logic [2:0] len, input logic [25:0] acc);
        result_t r;
        r = make_err(len);
        case (len)
            LEN_TWO: begin
                if (acc >= LEN2_MIN && acc < LEN2_LIM) begin
                    r.code_point = {10'd0, acc[10:0]};
                    r.is_error   = 1'b0;
                end
            end
            LEN_THREE: begin
                if (acc >= LEN3_MIN && !(acc >= SURR_LO && acc < SURR_HI) &&
                    acc < LEN3_LIM) begin
                    r.code_point = {5'd0, acc[15:0]};
                    r.is_error   = 1'b0;
                end
            end
            LEN_FOUR: begin
                if (acc >= LEN4_MIN && acc < LEN4_LIM) begin
                    r.code_point = acc[20:0];
                    r.is_error   = 1'b0;
                end
            end
            default: begin
                r = make_err(len);
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/utf8d_front.sv =====
// Front end: accepts bytes, tracks the open sequence and builds queue entries.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps

module utf8d_front
    import utf8d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       q_full,
    output logic       q_push,
    output entry_t     q_entry
);

    logic [25:0] acc_reg, acc_next;
    logic [2:0]  exp_reg, exp_next;
    logic [2:0]  seen_reg, seen_next;

    logic        accept;
    logic        seq_open;
    logic        is_cont;
    logic [25:0] acc_cont;
    logic [2:0]  seen_cont;

    logic        lead_has;
    result_t     lead_res;
    logic        lead_open;
    logic [2:0]  lead_len;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && !q_full;
    assign seq_open  = (exp_reg != LEN_NONE);
    assign is_cont   = (s_tdata[7:6] == 2'b10);
    assign acc_cont  = {acc_reg[19:0], s_tdata[5:0]};
    assign seen_cont = seen_reg + 3'd1;

    // Byte taken as a lead byte
    always_comb begin
        lead_has  = !s_tdata[7] || !s_tdata[6] || s_tlast;
        lead_open = s_tdata[7] && s_tdata[6] && !s_tlast;
        if (!s_tdata[7]) begin
            lead_res.code_point = {13'd0, s_tdata};
            lead_res.is_error   = 1'b0;
            lead_res.bytes_used = LEN_ONE;
        end else begin
            // stray continuation, or a lead cut off by end of stream
            lead_res = make_err(LEN_ONE);
        end
        if (s_tdata[5] && s_tdata[4]) begin
            lead_len = LEN_FOUR;
        end else if (s_tdata[5]) begin
            lead_len = LEN_THREE;
        end else begin
            lead_len = LEN_TWO;
        end
    end

    // Sequence state update and entry assembly
    always_comb begin
        acc_next  = acc_reg;
        exp_next  = exp_reg;
        seen_next = seen_reg;
        q_push    = 1'b0;
        q_entry.two    = 1'b0;
        q_entry.first  = lead_res;
        q_entry.second = lead_res;
        if (accept) begin
            if (seq_open && is_cont) begin
                if (seen_cont >= exp_reg) begin
                    q_push        = 1'b1;
                    q_entry.first = finish_seq(exp_reg, acc_cont);
                    acc_next      = '0;
                    exp_next      = LEN_NONE;
                    seen_next     = '0;
                end else if (s_tlast) begin
                    q_push        = 1'b1;
                    q_entry.first = make_err(seen_cont);
                    acc_next      = '0;
                    exp_next      = LEN_NONE;
                    seen_next     = '0;
                end else begin
                    acc_next  = acc_cont;
                    seen_next = seen_cont;
                end
            end else begin
                if (seq_open) begin
                    // broken sequence closes, then the byte starts anew
                    q_push        = 1'b1;
                    q_entry.first = make_err(seen_reg);
                    q_entry.two   = lead_has;
                end else begin
                    q_push = lead_has;
                end
                if (lead_open) begin
                    acc_next  = {18'd0, s_tdata};
                    exp_next  = lead_len;
                    seen_next = LEN_ONE;
                end else begin
                    acc_next  = '0;
                    exp_next  = LEN_NONE;
                    seen_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            exp_reg  <= LEN_NONE;
            seen_reg <= '0;
        end else begin
            acc_reg  <= acc_next;
            exp_reg  <= exp_next;
            seen_reg <= seen_next;
        end
    end

endmodule

// ===== rtl/utf8d_queue.sv =====
// Short FIFO of result entries between the front and the back.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps

module utf8d_queue
    import utf8d_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t pop_entry,
    output logic   empty
);

    entry_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = mem[rd_ptr_reg];

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + (QUEUE_AW)'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + (QUEUE_AW)'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/utf8d_back.sv =====
// Back end: unpacks queue entries into single results on the output channel.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps

module utf8d_back
    import utf8d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  entry_t      q_entry,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg, out_res_next;
    logic    out_last_reg, out_last_next;
    logic    pend_valid_reg, pend_valid_next;
    result_t pend_res_reg, pend_res_next;
    logic    out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = out_free && !pend_valid_reg && !q_empty;

    // Output register load: pending second result first, then the queue
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;
        if (out_free) begin
            if (pend_valid_reg) begin
                out_valid_next  = 1'b1;
                out_res_next    = pend_res_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end else if (!q_empty) begin
                out_valid_next  = 1'b1;
                out_res_next    = q_entry.first;
                out_last_next   = !q_entry.two;
                pend_valid_next = q_entry.two;
                pend_res_next   = q_entry.second;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
        pend_res_reg <= pend_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_res_reg.bytes_used, out_res_reg.is_error,
                       out_res_reg.code_point};

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// Channel  | Dir | Payload
// s_       | in  | tdata[7:0] in_byte, tlast ends_stream
// m_       | out | tdata[20:0] code_point, [21] is_error, [24:22] bytes_used,
//          |     | tlast last_of_run
//
// One byte is accepted per cycle while s_tready is high; a result passes through
// the queue and then the output register on its way to m_. A byte that yields
// two results occupies the output register with them one after the other, one
// result per cycle while m_tready is high. Reset (aresetn low, synchronous) drops
// any open sequence and empties the four-entry queue. s_tready falls only when
// that queue is full, so a stalled m_ side holds back the input after a few bytes.
// Top level of the UTF-8 stream decoder; depends on utf8d_pkg, utf8d_front,
// utf8d_queue and utf8d_back.
`timescale 1ns / 1ps

module utf8_stream_decoder
    import utf8d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // ends_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [20:0] code_point, [21] is_error, [24:22] bytes_used
    output logic        m_tlast    // last_of_run
);

    logic   q_push;
    entry_t q_push_entry;
    logic   q_full;
    logic   q_pop;
    entry_t q_pop_entry;
    logic   q_empty;

    // Byte intake and sequence tracking
    utf8d_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_push_entry)
    );

    // Decoupling queue
    utf8d_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_pop_entry),
        .empty      (q_empty)
    );

    // Result output
    utf8d_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_entry  (q_pop_entry),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/sv/utf8_stream_decoder_tb.sv =====
// Self-checking testbench for utf8_stream_decoder: directed and random UTF-8 byte
// streams, with the decoded code points checked against an in-bench predictor.
// Depends on utf8d_pkg and the utf8_stream_decoder RTL.
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;
    import utf8d_pkg::*;

    // One expected result plus its end-of-run marker
    typedef struct {
        result_t res;
        logic    last;
    } decoded_t;

    // Receiver behavior, picked per stretch of cycles
    typedef enum int {
        SINK_READY,
        SINK_COIN,
        SINK_RARE,
        SINK_PULSE
    } sink_mode_e;

    // Decoder state copy, expected code points and mismatch count
    class code_point_board;
        decoded_t    pending[$];
        int unsigned errors;
        logic [25:0] acc;
        logic [2:0]  want_len;
        logic [2:0]  seen;

        function new();
            errors = 0;
            clear_seq();
        endfunction

        function void clear_seq();
            acc      = '0;
            want_len = LEN_NONE;
            seen     = '0;
        endfunction

        function result_t error_of(input logic [2:0] used);
            result_t r;
            r.code_point = '0;
            r.is_error   = 1'b1;
            r.bytes_used = used;
            return r;
        endfunction

        // Range check of a complete sequence: overlong, surrogate, above U+10FFFF
        function result_t validate(input logic [2:0] len, input logic [25:0] a);
            result_t r;
            logic    ok;
            r  = error_of(len);
            ok = 1'b0;
            case (len)
                LEN_TWO: begin
                    ok = (a >= LEN2_MIN) && (a < LEN2_LIM);
                    r.code_point = 21'(a[10:0]);
                end
                LEN_THREE: begin
                    ok = (a >= LEN3_MIN) && (a < LEN3_LIM) && !((a >= SURR_LO) && (a < SURR_HI));
                    r.code_point = 21'(a[15:0]);
                end
                LEN_FOUR: begin
                    ok = (a >= LEN4_MIN) && (a < LEN4_LIM);
                    r.code_point = a[20:0];
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
            if (!ok)
                r = error_of(len);
            else
                r.is_error = 1'b0;
            return r;
        endfunction

        // Byte seen with no sequence open; returns 1 when it yields a result
        function logic take_lead(input logic [7:0] b, input logic ends, output result_t r);
            r = error_of(LEN_ONE);
            if (b[7] == 1'b0) begin
                r.code_point = 21'(b);
                r.is_error   = 1'b0;
                return 1'b1;
            end
            if (b[6] == 1'b0)
                return 1'b1;  // stray continuation
            acc  = 26'(b);
            seen = LEN_ONE;
            if (b >= 8'hF0)
                want_len = LEN_FOUR;
            else if (b >= 8'hE0)
                want_len = LEN_THREE;
            else
                want_len = LEN_TWO;
            if (ends) begin
                clear_seq();
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Accepted input transfer: advance the state and queue what it yields
        function void note_byte(input logic [7:0] b, input logic ends);
            result_t  fresh[$];
            result_t  r;
            decoded_t d;
            if (want_len != LEN_NONE) begin
                if (b[7:6] == 2'b10) begin
                    acc  = {acc[19:0], b[5:0]};
                    seen = seen + 3'd1;
                    if (seen >= want_len) begin
                        fresh.push_back(validate(want_len, acc));
                        clear_seq();
                    end else if (ends) begin
                        fresh.push_back(error_of(seen));
                        clear_seq();
                    end
                end else begin
                    // broken sequence, then the byte starts over as a lead
                    fresh.push_back(error_of(seen));
                    clear_seq();
                    if (take_lead(b, ends, r))
                        fresh.push_back(r);
                end
            end else if (take_lead(b, ends, r)) begin
                fresh.push_back(r);
            end
            foreach (fresh[i]) begin
                d.res  = fresh[i];
                d.last = (i == fresh.size() - 1);
                pending.push_back(d);
            end
        endfunction

        task report(input string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            errors++;
        endtask

        // Accepted output transfer: compare with the oldest expectation
        task check_result(input logic [31:0] data, input logic last);
            decoded_t d;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result tdata=%h tlast=%b", data, last));
                return;
            end
            d = pending.pop_front();
            if (data[20:0] !== d.res.code_point)
                report($sformatf("code_point %h, expected %h", data[20:0], d.res.code_point));
            if (data[21] !== d.res.is_error)
                report($sformatf("is_error %b, expected %b", data[21], d.res.is_error));
            if (data[24:22] !== d.res.bytes_used)
                report($sformatf("bytes_used %0d, expected %0d", data[24:22], d.res.bytes_used));
            if (data[31:25] !== 7'd0)
                report($sformatf("tdata padding %h, expected zero", data[31:25]));
            if (last !== d.last)
                report($sformatf("last_of_run %b, expected %b", last, d.last));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    sink_mode_e  sink_mode = SINK_READY;
    int unsigned sink_count = 0;

    logic [7:0]  stim_bytes[$];
    logic        stim_last[$];

    code_point_board board = new();

    utf8_stream_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Overall time limit
    initial begin
        #5_000_000;
        $display("utf8_stream_decoder_tb: done, errors");
        $finish;
    end

    task add_byte(input logic [7:0] b, input logic last);
        stim_bytes.push_back(b);
        stim_last.push_back(last);
    endtask

    // Encode cp in n bytes (overlong if cp is small), keep the first `keep`
    task add_code(input logic [20:0] cp, input int n, input int keep, input logic last);
        logic [7:0] seq[4];
        case (n)
            1: seq[0] = {1'b0, cp[6:0]};
            2: begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++)
            add_byte(seq[i], (i == keep - 1) ? last : 1'b0);
    endtask

    task build_stimulus();
        int unsigned pick;
        int          n;
        logic        stop;
        logic [20:0] cp;
        // directed: field extremes and each malformed form
        add_byte(8'h00, 1'b0);
        add_byte(8'h80, 1'b0);                  // stray continuation
        add_code(21'h80, 2, 2, 1'b0);
        add_code(21'h7FF, 2, 2, 1'b0);
        add_byte(8'hC0, 1'b0);                  // overlong two-byte form
        add_byte(8'h80, 1'b0);
        add_code(21'h800, 3, 3, 1'b0);
        add_code(21'hD800, 3, 3, 1'b0);         // surrogate
        add_code(21'h10FFFF, 4, 4, 1'b0);
        add_code(21'h140000, 4, 4, 1'b0);       // lead F5, above U+10FFFF
        add_byte(8'hF8, 1'b0);                  // sequence broken by ASCII
        add_byte(8'h41, 1'b0);
        add_code(21'h20AC, 3, 2, 1'b1);         // end of stream mid-sequence
        add_byte(8'hC3, 1'b1);                  // end of stream on a lead
        // random: mostly well-formed sequences, some broken ones and noise
        while (stim_bytes.size() < 1730) begin
            pick = $urandom_range(0, 99);
            stop = ($urandom_range(0, 23) == 0);
            if (pick < 25) begin
                add_code(21'($urandom_range(0, 8'h7F)), 1, 1, stop);
            end else if (pick < 45) begin
                add_code(21'($urandom_range(16'h80, 16'h7FF)), 2, 2, stop);
            end else if (pick < 65) begin
                if ($urandom_range(0, 7) == 0)
                    cp = 21'($urandom_range(16'hD800, 16'hDFFF));
                else
                    cp = 21'($urandom_range(16'h800, 16'hFFFF));
                add_code(cp, 3, 3, stop);
            end else if (pick < 80) begin
                add_code(21'($urandom_range(24'h10000, 24'h13FFFF)), 4, 4, stop);
            end else if (pick < 84) begin
                n = $urandom_range(2, 4);
                cp = 21'($urandom_range(0, (n == 2) ? 8'h7F : (n == 3) ? 16'h7FF : 16'hFFFF));
                add_code(cp, n, n, stop);
            end else if (pick < 87) begin
                add_byte(8'($urandom_range(8'hF5, 8'hFF)), 1'b0);
                for (int i = 0; i < 3; i++)
                    add_byte(8'($urandom_range(8'h80, 8'hBF)), (i == 2) ? stop : 1'b0);
            end else if (pick < 94) begin
                n = $urandom_range(2, 4);
                add_code(21'($urandom), n, $urandom_range(1, n - 1), stop);
            end else begin
                repeat ($urandom_range(1, 3))
                    add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
        end
    endtask

    // Sender: bursts of transfers with random gaps, then the drain and verdict
    initial begin
        int unsigned burst;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        build_stimulus();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        burst = $urandom_range(1, 20);
        for (int idx = 0; idx < stim_bytes.size(); idx++) begin
            s_tvalid <= 1'b1;
            s_tdata  <= stim_bytes[idx];
            s_tlast  <= stim_last[idx];
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            burst--;
            if (burst == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                    : $urandom_range(1, 20);
            end
        end
        s_tvalid <= 1'b0;
        // let the monitor note the last transfer before looking at the backlog
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.errors == 0)
            $display("utf8_stream_decoder_tb: done, clean");
        else
            $display("utf8_stream_decoder_tb: done, errors");
        $finish;
    end

    // Receiver stall pattern: a new mode is picked whenever sink_count runs out
    always @(posedge aclk) begin
        if (sink_count == 0) begin
            sink_mode  <= sink_mode_e'($urandom_range(0, 3));
            sink_count <= $urandom_range(20, 120);
        end else begin
            sink_count <= sink_count - 1;
        end
        case (sink_mode)
            SINK_READY: m_tready <= 1'b1;
            SINK_COIN:  m_tready <= 1'($urandom_range(0, 1));
            SINK_RARE:  m_tready <= ($urandom_range(0, 7) == 0);
            default:    m_tready <= (sink_count[3:0] < 4'd5);
        endcase
    end

    // Transfer monitor: inputs noted before outputs are checked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata, m_tlast);
        end
    end

endmodule
